@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the bounce accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBA_ASSERT_IMP(lbl_, clk_, rstn_, ante_, cons_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |-> (cons_)) \
    else $error("rba: implication check failed");

// next-cycle implication
`define RBA_ASSERT_NXT(lbl_, clk_, rstn_, ante_, cons_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |=> (cons_)) \
    else $error("rba: next-cycle check failed");

`endif

@@ sv/rba_pkg.sv @@
// ----------------------------------------------------------------------------
// rba_pkg
// Widths, constants and controller/datapath interface types of the
// radiosity bounce accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rba_pkg;

  localparam int SUM_WIDTH = 48;
  localparam int OUT_W     = 48;
  localparam int POS_W     = 32;
  localparam int NRM_W     = 16;
  localparam int L_W       = POS_W + 1;
  localparam int SQ_W      = 2 * POS_W;
  localparam int D2_W      = SQ_W + 2;
  localparam int PRD_W     = L_W + NRM_W;
  localparam int DOT_W     = PRD_W + 2;
  localparam int C_W       = PRD_W;
  localparam int E_W       = 32;
  localparam int RHO_W     = 17;
  localparam int MIN_W     = 32;
  localparam int ER_W      = E_W + RHO_W;
  localparam int OP_W      = D2_W;
  localparam int NUM_W     = ER_W + 2 + E_W + 2 * C_W;
  localparam int DEN_W     = 32 + 2 * D2_W;
  localparam int DV_W      = DEN_W + SUM_WIDTH;
  localparam int MUL_W     = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int CNT_W     = $clog2(SUM_WIDTH + 1);

  localparam int IN_TDATA_W  = 216;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [31:0]          PI_Q30  = 32'd3373259426;
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_REFLECTANCE = 1'b0;
  localparam cfg_idx_t CFG_MIN_DIST    = 1'b1;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_LAST = 2'd2;

  typedef logic [2:0] mul_idx_t;
  localparam mul_idx_t MUL_AREA = 3'd0;
  localparam mul_idx_t MUL_C1   = 3'd1;
  localparam mul_idx_t MUL_C2   = 3'd2;
  localparam mul_idx_t MUL_D2A  = 3'd3;
  localparam mul_idx_t MUL_D2B  = 3'd4;

  typedef struct packed {
    logic     capture;
    logic     tgt;
    logic     prod;
    logic     acc;
    logic     seed;
    logic     mul_start;
    logic     mul_step;
    logic     div_start;
    logic     div_step;
    logic     add;
    logic     emit;
    axis_t    axis;
    mul_idx_t mul_idx;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic mul_done;
    logic div_done;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/rba_ctrl.sv @@
// ----------------------------------------------------------------------------
// rba_ctrl
// Sequencer: walks one request through the target update or the axis
// products, shift-add multiply chain, restoring divide, sum update and emit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_req_type,
  input  rba_pkg::sts_t sts,
  output rba_pkg::cmd_t cmd
);
  import rba_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_TGT    = 12'b0000_0000_0010,
    ST_PROD   = 12'b0000_0000_0100,
    ST_ACC    = 12'b0000_0000_1000,
    ST_CHECK  = 12'b0000_0001_0000,
    ST_SEED   = 12'b0000_0010_0000,
    ST_MSTART = 12'b0000_0100_0000,
    ST_MSTEP  = 12'b0000_1000_0000,
    ST_DSTART = 12'b0001_0000_0000,
    ST_DSTEP  = 12'b0010_0000_0000,
    ST_ADD    = 12'b0100_0000_0000,
    ST_EMIT   = 12'b1000_0000_0000
  } state_t;

  state_t   state_r, state_nxt;
  axis_t    axis_r, axis_nxt;
  mul_idx_t idx_r, idx_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.axis      = axis_r;
    cmd.mul_idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          axis_nxt    = '0;
          state_nxt   = in_req_type ? ST_PROD : ST_TGT;
        end
      end
      ST_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (axis_r == AXIS_LAST) begin
          state_nxt = ST_CHECK;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_PROD;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.skip ? ST_EMIT : ST_SEED;
      end
      ST_SEED: begin
        cmd.seed  = 1'b1;
        idx_nxt   = MUL_AREA;
        state_nxt = ST_MSTART;
      end
      ST_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          if (idx_r == MUL_D2B) begin
            state_nxt = ST_DSTART;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = ST_MSTART;
          end
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `RBA_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, state_r != ST_IDLE)
  `RBA_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, !sts.out_busy && sts.last)
  `RBA_ASSERT_NXT(a_chain_to_div, clk, rst_n,
                  state_r == ST_MSTEP && sts.mul_done && idx_r == MUL_D2B,
                  state_r == ST_DSTART)

endmodule

`default_nettype wire

@@ sv/rba_dp.sv @@
// ----------------------------------------------------------------------------
// rba_dp
// Datapath: request capture, config registers, target state, axis
// products, shift-add multiplier, restoring divider, sum and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rba_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rba_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rba_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rba_pkg::cmd_t                      cmd,
  output rba_pkg::sts_t                      sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rba_pkg::OUT_W-1:0]          out_tdata,
  output logic                               out_tuser
);
  import rba_pkg::*;

  // configuration
  logic [RHO_W-1:0] rho_r;
  logic [MIN_W-1:0] min_r;

  // captured request
  logic signed [POS_W-1:0] pos_r [3];
  logic signed [NRM_W-1:0] nrm_r [3];
  logic [E_W-1:0]          area_r;
  logic [E_W-1:0]          emit_r;
  logic                    vis_r;
  logic                    last_r;

  // target state
  logic signed [POS_W-1:0] tpos_r [3];
  logic signed [NRM_W-1:0] tnrm_r [3];
  logic [SUM_WIDTH-1:0]    sum_r;
  logic                    clip_r;

  // geometry
  logic [SQ_W-1:0]          sq_r;
  logic signed [PRD_W-1:0]  p1_r, p2_r;
  logic [D2_W-1:0]          d2_r;
  logic signed [DOT_W-1:0]  c1_r, c2_r;

  // multiply chain
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [MUL_W-1:0] mc_r, pr_r;
  logic [OP_W-1:0]  mp_r;

  // divider
  logic [NUM_W-1:0]     rem_r;
  logic [DV_W-1:0]      dv_r;
  logic [CNT_W-1:0]     bcnt_r;
  logic [SUM_WIDTH-1:0] q_r;
  logic                 dsat_r;

  // result register
  logic                 out_vld_r;
  logic [OUT_W-1:0]     out_dat_r;
  logic                 out_sat_r;

  logic signed [L_W-1:0]   l_s;
  logic [L_W-1:0]          l_mag;
  logic signed [PRD_W-1:0] p1_c, p2_c;
  logic [ER_W-1:0]         er_c;
  logic [OP_W-1:0]         op_c;
  logic                    to_num;
  logic                    ge_c;
  logic [DV_W-1:0]         diff_c;

  assign cfg_ready = 1'b1;

  assign l_s   = L_W'(tpos_r[cmd.axis]) - L_W'(pos_r[cmd.axis]);
  assign l_mag = l_s[L_W-1] ? (-l_s) : l_s;
  assign p1_c  = PRD_W'(l_s) * PRD_W'(nrm_r[cmd.axis]);
  assign p2_c  = PRD_W'(l_s) * PRD_W'(tnrm_r[cmd.axis]);
  assign er_c  = ER_W'(emit_r) * ER_W'(rho_r);

  assign to_num = cmd.mul_idx inside {MUL_AREA, MUL_C1, MUL_C2};

  always_comb begin
    case (cmd.mul_idx)
      MUL_AREA: op_c = OP_W'(area_r);
      MUL_C1:   op_c = OP_W'(c1_r[C_W-1:0]);
      MUL_C2:   op_c = OP_W'(c2_r[C_W-1:0]);
      MUL_D2A:  op_c = d2_r;
      MUL_D2B:  op_c = d2_r;
      default:  op_c = '0;
    endcase
  end

  assign ge_c   = DV_W'(rem_r) >= dv_r;
  assign diff_c = DV_W'(rem_r) - dv_r;

  assign sts.skip     = !vis_r || (emit_r == '0) || (d2_r < D2_W'(min_r)) ||
                        (c1_r <= 0) || (c2_r <= 0);
  assign sts.mul_done = (mp_r == '0);
  assign sts.div_done = (bcnt_r == '0);
  assign sts.last     = last_r;
  assign sts.out_busy = out_vld_r && !out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_sat_r;

  // control state and registers with a defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_r     <= '0;
      min_r     <= MIN_W'(1);
      out_vld_r <= 1'b0;
      sum_r     <= '0;
      clip_r    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        tpos_r[k] <= '0;
        tnrm_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_REFLECTANCE: rho_r <= cfg_data[RHO_W-1:0];
          CFG_MIN_DIST:    min_r <= cfg_data[MIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.tgt) begin
        for (int k = 0; k < 3; k++) begin
          tpos_r[k] <= pos_r[k];
          tnrm_r[k] <= nrm_r[k];
        end
        sum_r  <= '0;
        clip_r <= 1'b0;
      end
      if (cmd.add) begin
        if (dsat_r || (q_r > (SUM_MAX - sum_r))) begin
          sum_r  <= SUM_MAX;
          clip_r <= 1'b1;
        end else begin
          sum_r <= sum_r + q_r;
        end
      end
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= in_tdata[POS_W*k +: POS_W];
        nrm_r[k] <= in_tdata[3*POS_W + NRM_W*k +: NRM_W];
      end
      area_r <= in_tdata[3*POS_W + 3*NRM_W +: E_W];
      emit_r <= in_tdata[3*POS_W + 3*NRM_W + E_W +: E_W];
      vis_r  <= in_tdata[3*POS_W + 3*NRM_W + 2*E_W];
      last_r <= in_tlast;
      d2_r   <= '0;
      c1_r   <= '0;
      c2_r   <= '0;
    end
    if (cmd.prod) begin
      sq_r <= SQ_W'(l_mag[POS_W-1:0]) * SQ_W'(l_mag[POS_W-1:0]);
      p1_r <= p1_c;
      p2_r <= p2_c;
    end
    if (cmd.acc) begin
      d2_r <= d2_r + D2_W'(sq_r);
      c1_r <= c1_r + DOT_W'(p1_r);
      c2_r <= c2_r - DOT_W'(p2_r);
    end
    if (cmd.seed) begin
      num_r <= NUM_W'({er_c, 2'b00});
      den_r <= DEN_W'(PI_Q30);
    end
    if (cmd.mul_start) begin
      mc_r <= to_num ? MUL_W'(num_r) : MUL_W'(den_r);
      mp_r <= op_c;
      pr_r <= '0;
    end
    if (cmd.mul_step) begin
      if (mp_r == '0) begin
        if (to_num) begin
          num_r <= pr_r[NUM_W-1:0];
        end else begin
          den_r <= pr_r[DEN_W-1:0];
        end
      end else begin
        if (mp_r[0]) begin
          pr_r <= pr_r + mc_r;
        end
        mc_r <= {mc_r[MUL_W-2:0], 1'b0};
        mp_r <= {1'b0, mp_r[OP_W-1:1]};
      end
    end
    if (cmd.div_start) begin
      rem_r  <= num_r;
      dv_r   <= {den_r, {SUM_WIDTH{1'b0}}};
      bcnt_r <= CNT_W'(SUM_WIDTH);
      q_r    <= '0;
      dsat_r <= 1'b0;
    end
    if (cmd.div_step) begin
      if (bcnt_r == CNT_W'(SUM_WIDTH)) begin
        dsat_r <= ge_c;
      end else begin
        if (ge_c) begin
          rem_r <= diff_c[NUM_W-1:0];
        end
        q_r <= {q_r[SUM_WIDTH-2:0], ge_c};
      end
      dv_r   <= {1'b0, dv_r[DV_W-1:1]};
      bcnt_r <= bcnt_r - CNT_W'(1);
    end
    if (cmd.emit) begin
      out_dat_r <= OUT_W'(sum_r);
      out_sat_r <= clip_r;
    end
  end

  `RBA_ASSERT_IMP(a_clip_pins_sum, clk, rst_n, clip_r, sum_r == SUM_MAX)
  `RBA_ASSERT_IMP(a_div_count_range, clk, rst_n, cmd.div_step, bcnt_r <= CNT_W'(SUM_WIDTH))
  `RBA_ASSERT_NXT(a_emit_sets_valid, clk, rst_n, cmd.emit, out_vld_r)

endmodule

`default_nettype wire

@@ sv/radiosity_bounce_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// radiosity_bounce_accumulator_core
// Gathers one diffuse bounce onto a target patch, point to patch form factor.
// ----------------------------------------------------------------------------
// One request at a time. A target request (tuser 0) copies the captured
// position and normal into the target state and clears the sum. A source
// request either skips its term or sums it: a shift-add
// multiplier retires one operand bit per cycle and stops at the operand's top
// set bit (area, both dot products, d2 twice), then a restoring divider checks
// for overflow and retires one quotient bit per cycle. A request with tlast set
// loads the running sum into the output register; a result waiting there
// does not block the next request unless that request also ends a run.
// ----------------------------------------------------------------------------
`default_nettype none

module radiosity_bounce_accumulator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, patch_area, emitted_value,
  // visible, zero pad
  input  logic [rba_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,   // req_type
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rba_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [rba_pkg::OUT_W-1:0]         out_tdata,  // gathered_light
  output logic                              out_tuser,  // saturated
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import rba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .sts         (sts),
    .cmd         (cmd)
  );

  rba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
